/* rtl/core/spsf_pkg.sv */
`default_nettype none
package spsf_pkg;

  localparam int MAX_ITEMS   = 64;
  localparam int MAX_RESULTS = 32;
  localparam int IDX_W       = $clog2(MAX_ITEMS);
  localparam int CNT_W       = $clog2(MAX_ITEMS + 1);
  localparam int RES_W       = $clog2(MAX_RESULTS + 1);
  localparam int VAL_W       = 16;
  localparam int TGT_W       = 17;
  localparam int APB_DW      = 32;
  localparam int APB_AW      = 3;

  // Register index taken from paddr[APB_AW-1:2]
  localparam logic [APB_AW-3:0] REG_TARGET_SUM = '0;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_READ,
    ST_CMP,
    ST_DONE
  } walk_state_t;

endpackage
`default_nettype wire

/* rtl/core/spsf_mem.sv */
`default_nettype none
module spsf_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr_a,
  input  wire logic [AW-1:0]    raddr_b,
  output logic      [WIDTH-1:0] rdata_a,
  output logic      [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
`default_nettype wire

/* rtl/core/spsf_cfg.sv */
`default_nettype none
module spsf_cfg (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [spsf_pkg::APB_AW-1:0]         paddr,
  input  wire logic [spsf_pkg::APB_DW-1:0]         pwdata,
  output logic      [spsf_pkg::APB_DW-1:0]         prdata,
  output logic                                     pready,
  output logic signed [spsf_pkg::TGT_W-1:0]        target_sum
);
  import spsf_pkg::*;

  logic signed [TGT_W-1:0] target_r;
  logic signed [TGT_W-1:0] target_nxt;
  logic                    hit;

  assign hit = (paddr[APB_AW-1:2] == REG_TARGET_SUM);

  always_comb begin
    target_nxt = target_r;
    if (psel && penable && pwrite && hit) begin
      target_nxt = pwdata[TGT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
    end else begin
      target_r <= target_nxt;
    end
  end

  assign prdata     = hit ? {{(APB_DW-TGT_W){1'b0}}, target_r} : '0;
  assign pready     = 1'b1;
  assign target_sum = target_r;

endmodule
`default_nettype wire

/* rtl/core/sorted_pair_sum_finder_core.sv */
`default_nettype none
// Loading: start is taken every cycle while busy is low; one element per cycle.
// Search: the final item raises busy; each two-pointer step is a read state then a compare state,
//   at most stored_count-1 steps, then a last pointer check (skipped when the result limit
//   ends the walk) and a closing state.
// Results: one-cycle out_valid strobe, registered in the cycle after the decision; no stall.
// Reset (rst_n low, synchronous) clears count, pointers and flags; store is left as is.
module sorted_pair_sum_finder_core (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // input items
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic signed [spsf_pkg::VAL_W-1:0] in_value,
  input  wire logic                              in_is_final,
  // results
  output logic                                   out_valid,
  output logic signed [spsf_pkg::VAL_W-1:0]      out_larger_value,
  output logic signed [spsf_pkg::VAL_W-1:0]      out_smaller_value,
  output logic                                   out_pair_valid,
  output logic                                   out_overflowed,
  output logic                                   out_end_of_run,
  // configuration
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [spsf_pkg::APB_AW-1:0]       paddr,
  input  wire logic [spsf_pkg::APB_DW-1:0]       pwdata,
  output logic      [spsf_pkg::APB_DW-1:0]       prdata,
  output logic                                   pready
);
  import spsf_pkg::*;

  logic signed [TGT_W-1:0] target_sum;

  walk_state_t state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] low_r, low_nxt;
  logic [IDX_W-1:0] high_r, high_nxt;
  logic [RES_W-1:0] res_cnt_r, res_cnt_nxt;
  logic             ovf_r, ovf_nxt;
  // A matched pair is held back until we know whether it closes the run.
  logic             pend_v_r, pend_v_nxt;
  logic [VAL_W-1:0] pend_hi_r, pend_hi_nxt;
  logic [VAL_W-1:0] pend_lo_r, pend_lo_nxt;

  logic             emit;
  logic [VAL_W-1:0] emit_hi, emit_lo;
  logic             emit_pair, emit_end;

  logic             accept;
  logic             mem_we;
  logic [VAL_W-1:0] rd_lo, rd_hi;
  logic signed [TGT_W-1:0] sum;
  logic [CNT_W-1:0] count_inc;

  logic             out_valid_r;
  logic [VAL_W-1:0] out_hi_r, out_lo_r;
  logic             out_pair_r, out_ovf_r, out_end_r;

  spsf_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .target_sum (target_sum)
  );

  // Value store: one write port for loading, two read ports for the pointers.
  spsf_mem #(
    .DEPTH (MAX_ITEMS),
    .WIDTH (VAL_W)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (count_r[IDX_W-1:0]),
    .wdata   (in_value),
    .raddr_a (low_r),
    .raddr_b (high_r),
    .rdata_a (rd_lo),
    .rdata_b (rd_hi)
  );

  assign busy   = (state_r != ST_LOAD);
  assign accept = start && !busy;
  assign mem_we = accept && (count_r < CNT_W'(MAX_ITEMS));

  assign sum = TGT_W'(signed'(rd_lo)) + TGT_W'(signed'(rd_hi));
  assign count_inc = mem_we ? count_r + 1'b1 : count_r;

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    low_nxt     = low_r;
    high_nxt    = high_r;
    res_cnt_nxt = res_cnt_r;
    ovf_nxt     = ovf_r;
    pend_v_nxt  = pend_v_r;
    pend_hi_nxt = pend_hi_r;
    pend_lo_nxt = pend_lo_r;
    emit        = 1'b0;
    emit_hi     = pend_hi_r;
    emit_lo     = pend_lo_r;
    emit_pair   = 1'b1;
    emit_end    = 1'b0;

    unique case (state_r)
      ST_LOAD: begin
        if (accept) begin
          count_nxt = count_inc;
          if (!mem_we) begin
            ovf_nxt = 1'b1;
          end
          if (in_is_final) begin
            // count_inc is at least one here: a full store still holds MAX_ITEMS.
            low_nxt     = '0;
            high_nxt    = IDX_W'(count_inc - 1'b1);
            res_cnt_nxt = '0;
            pend_v_nxt  = 1'b0;
            state_nxt   = ST_READ;
          end
        end
      end
      ST_READ: begin
        // Store reads both pointers at this edge.
        state_nxt = (low_r < high_r) ? ST_CMP : ST_DONE;
      end
      ST_CMP: begin
        state_nxt = ST_READ;
        if (sum == target_sum) begin
          // Release the previous pair, hold this one.
          emit        = pend_v_r;
          pend_v_nxt  = 1'b1;
          pend_hi_nxt = rd_hi;
          pend_lo_nxt = rd_lo;
          low_nxt     = low_r + 1'b1;
          high_nxt    = high_r - 1'b1;
          res_cnt_nxt = res_cnt_r + 1'b1;
          if (res_cnt_nxt == RES_W'(MAX_RESULTS)) begin
            state_nxt = ST_DONE;
          end
        end else if (sum > target_sum) begin
          high_nxt = high_r - 1'b1;
        end else begin
          low_nxt = low_r + 1'b1;
        end
      end
      ST_DONE: begin
        // Close the run: last held pair, or a single not-found.
        emit      = 1'b1;
        emit_end  = 1'b1;
        emit_pair = pend_v_r;
        if (!pend_v_r) begin
          emit_hi = '0;
          emit_lo = '0;
        end
        count_nxt   = '0;
        ovf_nxt     = 1'b0;
        pend_v_nxt  = 1'b0;
        res_cnt_nxt = '0;
        low_nxt     = '0;
        high_nxt    = '0;
        state_nxt   = ST_LOAD;
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      low_r       <= '0;
      high_r      <= '0;
      res_cnt_r   <= '0;
      ovf_r       <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      low_r       <= low_nxt;
      high_r      <= high_nxt;
      res_cnt_r   <= res_cnt_nxt;
      ovf_r       <= ovf_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= emit;
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    pend_hi_r <= pend_hi_nxt;
    pend_lo_r <= pend_lo_nxt;
    if (emit) begin
      out_hi_r   <= emit_hi;
      out_lo_r   <= emit_lo;
      out_pair_r <= emit_pair;
      out_ovf_r  <= ovf_r;
      out_end_r  <= emit_end;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_larger_value  = out_hi_r;
  assign out_smaller_value = out_lo_r;
  assign out_pair_valid    = out_pair_r;
  assign out_overflowed    = out_ovf_r;
  assign out_end_of_run    = out_end_r;

  // Compare only ever sees pointers that passed the bounds check.
  a_cmp_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CMP |-> low_r < high_r)
    else $error("compare with crossed pointers");

  // Closing result lands after the walk has returned to loading.
  a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_of_run |-> !busy && count_r == '0)
    else $error("run closed while still walking");

  // Intermediate results only appear mid-walk.
  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_end_of_run |-> busy && out_pair_valid)
    else $error("stray intermediate result");

  // Not-found is always the single closing result.
  a_nf_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_pair_valid |-> out_end_of_run)
    else $error("not-found result without end of run");

endmodule
`default_nettype wire
